// File: rtl/dpx_pkg.sv
// Shared types and constants for the data-processing execute unit.
`timescale 1ns / 1ps

package dpx_pkg;

    typedef enum logic [1:0] {
        ST_SKIPPED     = 2'd0,
        ST_EXECUTED    = 2'd1,
        ST_UNSUPPORTED = 2'd2
    } status_t;

    typedef enum logic [3:0] {
        OP_AND = 4'h0,
        OP_EOR = 4'h1,
        OP_SUB = 4'h2,
        OP_RSB = 4'h3,
        OP_ADD = 4'h4,
        OP_ADC = 4'h5,
        OP_SBC = 4'h6,
        OP_RSC = 4'h7,
        OP_TST = 4'h8,
        OP_TEQ = 4'h9,
        OP_CMP = 4'hA,
        OP_CMN = 4'hB,
        OP_ORR = 4'hC,
        OP_MOV = 4'hD,
        OP_BIC = 4'hE,
        OP_MVN = 4'hF
    } op_t;

    typedef enum logic [3:0] {
        COND_EQ = 4'h0,
        COND_NE = 4'h1,
        COND_CS = 4'h2,
        COND_CC = 4'h3,
        COND_MI = 4'h4,
        COND_PL = 4'h5,
        COND_VS = 4'h6,
        COND_VC = 4'h7,
        COND_HI = 4'h8,
        COND_LS = 4'h9,
        COND_GE = 4'hA,
        COND_LT = 4'hB,
        COND_GT = 4'hC,
        COND_LE = 4'hD,
        COND_AL = 4'hE,
        COND_NV = 4'hF
    } cond_t;

    typedef enum logic [1:0] {
        SHIFT_LSL = 2'd0,
        SHIFT_LSR = 2'd1,
        SHIFT_ASR = 2'd2,
        SHIFT_ROR = 2'd3
    } shift_t;

    localparam logic [1:0] CLASS_DP     = 2'b00;
    localparam logic [1:0] CLASS_BRANCH = 2'b10;
    localparam logic [3:0] MUL_MARK     = 4'b1001;
    localparam logic [3:0] REG_PC       = 4'd15;
    localparam logic [3:0] REG_LINK     = 4'd14;
    localparam int unsigned NUM_GP      = 15;

endpackage

// File: rtl/arm_data_processing_execute.sv
// Top level: one-instruction-per-beat data-processing execute unit.
//
//  channel      | direction | handshake                        | payload
//  instruction  | in        | instruction_valid/_stall         | instruction[31:0]
//  result       | out       | result_valid/_stall              | status, reg_written,
//               |           |                                  | reg_index, reg_value,
//               |           |                                  | flags_out, pc_out
//
// One beat per cycle sustained while result_stall is low. The decode registers take
// the word and three register-file reads; the execute stage then runs shift, ALU or
// multiply, commits state and loads the result register.
// Reset clears r0..r14 (through per-entry valid bits), pc and flags at once.
// A stalled result holds the execute stage, which then stalls the input.
`timescale 1ns / 1ps

module arm_data_processing_execute #(
    parameter int unsigned PC_STEP = 4
) (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        instruction_valid,
    output logic        instruction_stall,
    input  logic [31:0] instruction,
    output logic        result_valid,
    input  logic        result_stall,
    output logic [1:0]  status,
    output logic        reg_written,
    output logic [3:0]  reg_index,
    output logic [31:0] reg_value,
    output logic [3:0]  flags_out,
    output logic [31:0] pc_out
);

    // register file: two copies so three operands can be read per beat
    logic [31:0] gpa_mem [dpx_pkg::NUM_GP];
    logic [31:0] gpb_mem [dpx_pkg::NUM_GP];
    logic [dpx_pkg::NUM_GP-1:0] gp_vld_reg;

    logic [31:0] pc_reg;
    logic [3:0]  nzcv_reg;

    // decode stage
    logic        ir_valid_reg;
    logic [31:0] ir_reg;
    logic [31:0] raw_a_reg, raw_m_reg, raw_s_reg;
    logic        vld_a_reg, vld_m_reg, vld_s_reg;
    logic        hit_a_reg, hit_m_reg, hit_s_reg;
    logic [31:0] byp_reg;

    // result stage
    logic        result_valid_reg;
    logic [1:0]  status_reg;
    logic        reg_written_reg;
    logic [3:0]  reg_index_reg;
    logic [31:0] reg_value_reg;
    logic [3:0]  flags_out_reg;
    logic [31:0] pc_out_reg;

    logic        in_fire, out_free, ex_fire;
    logic        in_is_mul;
    logic [3:0]  in_addr_a, in_addr_m, in_addr_s;

    // execute signals
    logic [3:0]  ex_addr_a, ex_addr_m, ex_addr_s;
    logic        ex_is_mul;
    logic [31:0] pc_adv;
    logic [31:0] op_a, op_m, op_s;
    logic        flag_n, flag_z, flag_c, flag_v;
    logic        cond_ok;
    logic [7:0]  sh_amt;
    logic [31:0] sh_val;
    logic        sh_c;
    logic [31:0] op_b;
    logic        op_bc;
    dpx_pkg::op_t opcode;
    logic [31:0] add_x, add_y;
    logic        add_ci;
    logic [32:0] add_sum;
    logic [31:0] add_res;
    logic        add_v;
    logic [31:0] prod;
    logic [31:0] mul_res;
    logic [31:0] br_off;

    dpx_pkg::status_t ex_status;
    logic        ex_wr;
    logic [3:0]  ex_widx;
    logic [31:0] ex_wval;
    logic [3:0]  nzcv_next;
    logic [31:0] pc_next;
    logic        ex_mem_we;

    // ---------------- handshake ----------------
    assign out_free          = !result_valid_reg || !result_stall;
    assign ex_fire           = ir_valid_reg && out_free;
    assign instruction_stall = ir_valid_reg && !out_free;
    assign in_fire           = instruction_valid && !instruction_stall;

    // ---------------- decode: read addresses ----------------
    assign in_is_mul = (instruction[27:26] == dpx_pkg::CLASS_DP)
                    && (instruction[7:4] == dpx_pkg::MUL_MARK);
    assign in_addr_a = in_is_mul ? instruction[15:12] : instruction[19:16];
    assign in_addr_m = instruction[3:0];
    assign in_addr_s = instruction[11:8];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            ir_valid_reg <= 1'b0;
        end
        else if (in_fire)
        begin
            ir_valid_reg <= 1'b1;
        end
        else if (ex_fire)
        begin
            ir_valid_reg <= 1'b0;
        end
    end

    // load the word with its operand reads; forward the write committing this edge
    always_ff @(posedge clk)
    begin
        if (in_fire)
        begin
            ir_reg    <= instruction;
            raw_a_reg <= gpa_mem[in_addr_a];
            raw_m_reg <= gpa_mem[in_addr_m];
            raw_s_reg <= gpb_mem[in_addr_s];
            vld_a_reg <= (in_addr_a != dpx_pkg::REG_PC) && gp_vld_reg[in_addr_a];
            vld_m_reg <= (in_addr_m != dpx_pkg::REG_PC) && gp_vld_reg[in_addr_m];
            vld_s_reg <= (in_addr_s != dpx_pkg::REG_PC) && gp_vld_reg[in_addr_s];
            hit_a_reg <= ex_fire && ex_mem_we && (ex_widx == in_addr_a);
            hit_m_reg <= ex_fire && ex_mem_we && (ex_widx == in_addr_m);
            hit_s_reg <= ex_fire && ex_mem_we && (ex_widx == in_addr_s);
            byp_reg   <= ex_wval;
        end
    end

    // ---------------- execute ----------------
    assign ex_is_mul = (ir_reg[27:26] == dpx_pkg::CLASS_DP)
                    && (ir_reg[7:4] == dpx_pkg::MUL_MARK);
    assign ex_addr_a = ex_is_mul ? ir_reg[15:12] : ir_reg[19:16];
    assign ex_addr_m = ir_reg[3:0];
    assign ex_addr_s = ir_reg[11:8];
    assign pc_adv    = pc_reg + 32'(PC_STEP);

    always_comb
    begin
        if (hit_a_reg)
            op_a = byp_reg;
        else if (ex_addr_a == dpx_pkg::REG_PC)
            op_a = pc_adv;
        else
            op_a = vld_a_reg ? raw_a_reg : 32'd0;

        if (hit_m_reg)
            op_m = byp_reg;
        else if (ex_addr_m == dpx_pkg::REG_PC)
            op_m = pc_adv;
        else
            op_m = vld_m_reg ? raw_m_reg : 32'd0;

        if (hit_s_reg)
            op_s = byp_reg;
        else if (ex_addr_s == dpx_pkg::REG_PC)
            op_s = pc_adv;
        else
            op_s = vld_s_reg ? raw_s_reg : 32'd0;
    end

    assign flag_n = nzcv_reg[3];
    assign flag_z = nzcv_reg[2];
    assign flag_c = nzcv_reg[1];
    assign flag_v = nzcv_reg[0];

    always_comb
    begin
        case (dpx_pkg::cond_t'(ir_reg[31:28]))
            dpx_pkg::COND_EQ: cond_ok = flag_z;
            dpx_pkg::COND_NE: cond_ok = !flag_z;
            dpx_pkg::COND_CS: cond_ok = flag_c;
            dpx_pkg::COND_CC: cond_ok = !flag_c;
            dpx_pkg::COND_MI: cond_ok = flag_n;
            dpx_pkg::COND_PL: cond_ok = !flag_n;
            dpx_pkg::COND_VS: cond_ok = flag_v;
            dpx_pkg::COND_VC: cond_ok = !flag_v;
            dpx_pkg::COND_HI: cond_ok = flag_c && !flag_z;
            dpx_pkg::COND_LS: cond_ok = !flag_c || flag_z;
            dpx_pkg::COND_GE: cond_ok = (flag_n == flag_v);
            dpx_pkg::COND_LT: cond_ok = (flag_n != flag_v);
            dpx_pkg::COND_GT: cond_ok = !flag_z && (flag_n == flag_v);
            dpx_pkg::COND_LE: cond_ok = flag_z || (flag_n != flag_v);
            dpx_pkg::COND_AL: cond_ok = 1'b1;
            default:          cond_ok = 1'b0;
        endcase
    end

    // barrel shifter; ROR is left as a pass-through
    assign sh_amt = ir_reg[4] ? op_s[7:0] : {3'd0, ir_reg[11:7]};

    always_comb
    begin
        logic [32:0] lsl_t;
        logic [32:0] lsr_t;
        logic [32:0] asr_t;
        lsl_t  = {1'b0, op_m} << sh_amt[4:0];
        lsr_t  = {op_m, 1'b0} >> sh_amt[4:0];
        asr_t  = 33'($signed({op_m, 1'b0}) >>> sh_amt[4:0]);
        sh_val = op_m;
        sh_c   = flag_c;
        if (sh_amt != 8'd0)
        begin
            case (dpx_pkg::shift_t'(ir_reg[6:5]))
                dpx_pkg::SHIFT_LSL:
                begin
                    if (sh_amt < 8'd32)
                    begin
                        sh_val = lsl_t[31:0];
                        sh_c   = lsl_t[32];
                    end
                    else
                    begin
                        sh_val = 32'd0;
                        sh_c   = (sh_amt == 8'd32) ? op_m[0] : 1'b0;
                    end
                end
                dpx_pkg::SHIFT_LSR:
                begin
                    if (sh_amt < 8'd32)
                    begin
                        sh_val = lsr_t[32:1];
                        sh_c   = lsr_t[0];
                    end
                    else
                    begin
                        sh_val = 32'd0;
                        sh_c   = (sh_amt == 8'd32) ? op_m[31] : 1'b0;
                    end
                end
                dpx_pkg::SHIFT_ASR:
                begin
                    if (sh_amt < 8'd32)
                    begin
                        sh_val = asr_t[32:1];
                        sh_c   = asr_t[0];
                    end
                    else
                    begin
                        sh_val = {32{op_m[31]}};
                        sh_c   = op_m[31];
                    end
                end
                default:
                begin
                    sh_val = op_m;
                    sh_c   = flag_c;
                end
            endcase
        end
    end

    // immediate operand is imm8 unrotated, carry kept
    assign op_b  = ir_reg[25] ? {24'd0, ir_reg[7:0]} : sh_val;
    assign op_bc = ir_reg[25] ? flag_c : sh_c;

    assign opcode = dpx_pkg::op_t'(ir_reg[24:21]);

    // one adder serves all arithmetic ops
    always_comb
    begin
        add_x  = op_a;
        add_y  = op_b;
        add_ci = 1'b0;
        case (opcode)
            dpx_pkg::OP_SUB, dpx_pkg::OP_CMP:
            begin
                add_y  = ~op_b;
                add_ci = 1'b1;
            end
            dpx_pkg::OP_RSB:
            begin
                add_x  = op_b;
                add_y  = ~op_a;
                add_ci = 1'b1;
            end
            dpx_pkg::OP_ADC:
            begin
                add_ci = flag_c;
            end
            dpx_pkg::OP_SBC:
            begin
                add_y  = ~op_b;
                add_ci = flag_c;
            end
            dpx_pkg::OP_RSC:
            begin
                add_x  = op_b;
                add_y  = ~op_a;
                add_ci = flag_c;
            end
            default:
            begin
                add_x  = op_a;
                add_y  = op_b;
                add_ci = 1'b0;
            end
        endcase
    end

    assign add_sum = {1'b0, add_x} + {1'b0, add_y} + {32'd0, add_ci};
    assign add_res = add_sum[31:0];
    assign add_v   = ~(add_x[31] ^ add_y[31]) & (add_x[31] ^ add_res[31]);

    assign prod    = op_m * op_s;
    assign mul_res = prod + (ir_reg[21] ? op_a : 32'd0);

    assign br_off  = {{6{ir_reg[23]}}, ir_reg[23:0], 2'b00};

    always_comb
    begin
        logic [31:0] lres;
        logic        arith;
        lres      = 32'd0;
        arith     = 1'b0;
        ex_status = dpx_pkg::ST_EXECUTED;
        ex_wr     = 1'b0;
        ex_widx   = 4'd0;
        ex_wval   = 32'd0;
        nzcv_next = nzcv_reg;
        pc_next   = pc_adv;
        if (!cond_ok)
        begin
            ex_status = dpx_pkg::ST_SKIPPED;
        end
        else if (ex_is_mul)
        begin
            ex_wr   = 1'b1;
            ex_widx = ir_reg[19:16];
            ex_wval = mul_res;
            if (ir_reg[20])
                nzcv_next = {mul_res[31], mul_res == 32'd0, nzcv_reg[1:0]};
        end
        else if (ir_reg[27:26] == dpx_pkg::CLASS_DP)
        begin
            arith = opcode inside {dpx_pkg::OP_SUB, dpx_pkg::OP_RSB, dpx_pkg::OP_ADD,
                                   dpx_pkg::OP_ADC, dpx_pkg::OP_SBC, dpx_pkg::OP_RSC,
                                   dpx_pkg::OP_CMP, dpx_pkg::OP_CMN};
            case (opcode)
                dpx_pkg::OP_AND, dpx_pkg::OP_TST: lres = op_a & op_b;
                dpx_pkg::OP_EOR, dpx_pkg::OP_TEQ: lres = op_a ^ op_b;
                dpx_pkg::OP_ORR:                  lres = op_a | op_b;
                dpx_pkg::OP_MOV:                  lres = op_b;
                dpx_pkg::OP_BIC:                  lres = op_a & ~op_b;
                dpx_pkg::OP_MVN:                  lres = ~op_b;
                default:                          lres = add_res;
            endcase
            // compares only touch flags
            if (!(opcode inside {dpx_pkg::OP_TST, dpx_pkg::OP_TEQ,
                                 dpx_pkg::OP_CMP, dpx_pkg::OP_CMN}))
            begin
                ex_wr   = 1'b1;
                ex_widx = ir_reg[15:12];
                ex_wval = lres;
            end
            if (ir_reg[20])
            begin
                if (arith)
                    nzcv_next = {lres[31], lres == 32'd0, add_sum[32], add_v};
                else
                    nzcv_next = {lres[31], lres == 32'd0, op_bc, nzcv_reg[0]};
            end
        end
        else if ((ir_reg[27:26] == dpx_pkg::CLASS_BRANCH) && ir_reg[25])
        begin
            if (ir_reg[24])
            begin
                ex_wr   = 1'b1;
                ex_widx = dpx_pkg::REG_LINK;
                ex_wval = pc_adv;
            end
            pc_next = pc_adv + br_off;
        end
        else
        begin
            ex_status = dpx_pkg::ST_UNSUPPORTED;
        end
        // a write to r15 redirects the pc
        if (ex_wr && (ex_widx == dpx_pkg::REG_PC))
            pc_next = ex_wval;
    end

    assign ex_mem_we = ex_wr && (ex_widx != dpx_pkg::REG_PC);

    // ---------------- commit ----------------
    always_ff @(posedge clk)
    begin
        if (ex_fire && ex_mem_we)
        begin
            gpa_mem[ex_widx] <= ex_wval;
            gpb_mem[ex_widx] <= ex_wval;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            gp_vld_reg <= '0;
            pc_reg     <= 32'd0;
            nzcv_reg   <= 4'd0;
        end
        else if (ex_fire)
        begin
            if (ex_mem_we)
                gp_vld_reg[ex_widx] <= 1'b1;
            pc_reg   <= pc_next;
            nzcv_reg <= nzcv_next;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            result_valid_reg <= 1'b0;
        end
        else if (ex_fire)
        begin
            result_valid_reg <= 1'b1;
        end
        else if (!result_stall)
        begin
            result_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (ex_fire)
        begin
            status_reg      <= ex_status;
            reg_written_reg <= ex_wr;
            reg_index_reg   <= ex_widx;
            reg_value_reg   <= ex_wval;
            flags_out_reg   <= nzcv_next;
            pc_out_reg      <= pc_next;
        end
    end

    assign result_valid = result_valid_reg;
    assign status       = status_reg;
    assign reg_written  = reg_written_reg;
    assign reg_index    = reg_index_reg;
    assign reg_value    = reg_value_reg;
    assign flags_out    = flags_out_reg;
    assign pc_out       = pc_out_reg;

`ifndef SYNTHESIS
    a_fire_gives_result: assert property (@(posedge clk) disable iff (!rst_n)
        ex_fire |=> result_valid_reg)
        else $error("executed beat produced no result");

    a_skip_no_write: assert property (@(posedge clk) disable iff (!rst_n)
        ex_fire && !cond_ok |-> !ex_wr && (nzcv_next == nzcv_reg) && (pc_next == pc_adv))
        else $error("skipped beat changed state");

    a_unsupported_keeps_flags: assert property (@(posedge clk) disable iff (!rst_n)
        ex_fire && (ex_status == dpx_pkg::ST_UNSUPPORTED) |=> nzcv_reg == $past(nzcv_reg))
        else $error("unsupported beat changed flags");

    a_flags_report: assert property (@(posedge clk) disable iff (!rst_n)
        ex_fire |=> flags_out_reg == nzcv_reg && pc_out_reg == pc_reg)
        else $error("reported flags or pc differ from committed state");

    a_no_write_zero: assert property (@(posedge clk) disable iff (!rst_n)
        result_valid_reg && !reg_written_reg |-> reg_index_reg == 4'd0 && reg_value_reg == 32'd0)
        else $error("result reports write data without a write");
`endif

endmodule

// File: tb/arm_data_processing_execute_tb.sv
// Self-checking testbench for the data-processing execute unit.
`timescale 1ns / 1ps

module arm_data_processing_execute_tb;

    localparam int unsigned PC_STEP = 4;
    localparam logic [1:0] CLASS_XFER   = 2'b01;
    localparam logic [1:0] CLASS_COPROC = 2'b11;

    typedef struct packed {
        dpx_pkg::status_t status;
        logic        wr;
        logic [3:0]  idx;
        logic [31:0] val;
        logic [3:0]  flags;
        logic [31:0] pc;
    } step_result_t;

    logic        clk = 1'b0;
    logic        rst_n = 1'b0;
    logic        instruction_valid = 1'b0;
    logic        instruction_stall;
    logic [31:0] instruction = '0;
    logic        result_valid;
    logic        result_stall = 1'b0;
    logic [1:0]  status;
    logic        reg_written;
    logic [3:0]  reg_index;
    logic [31:0] reg_value;
    logic [3:0]  flags_out;
    logic [31:0] pc_out;

    // architectural state as the core should see it
    logic [31:0] gpr_model [dpx_pkg::NUM_GP];
    logic [31:0] pc_model;
    logic [3:0]  nzcv_model;

    step_result_t expected_q [$];
    int mismatches = 0;
    int stall_left = 0;
    logic no_idle = 1'b0;

    arm_data_processing_execute #(
        .PC_STEP(PC_STEP)
    ) u_top (
        .clk(clk),
        .rst_n(rst_n),
        .instruction_valid(instruction_valid),
        .instruction_stall(instruction_stall),
        .instruction(instruction),
        .result_valid(result_valid),
        .result_stall(result_stall),
        .status(status),
        .reg_written(reg_written),
        .reg_index(reg_index),
        .reg_value(reg_value),
        .flags_out(flags_out),
        .pc_out(pc_out)
    );

    always
    begin
        #1 clk = 1'b1;
        #1 clk = 1'b0;
    end

    initial
    begin
        #1000000;
        $display("arm_data_processing_execute_tb NOT OK");
        $finish;
    end

    function automatic int pick_gap();
        int r;
        if (no_idle)
            return 0;
        r = $urandom_range(0, 99);
        if (r < 55)
            return 0;
        if (r < 92)
            return $urandom_range(1, 3);
        return $urandom_range(6, 24);
    endfunction

    function automatic logic [31:0] read_reg(input logic [3:0] i);
        return (i == dpx_pkg::REG_PC) ? pc_model : gpr_model[i];
    endfunction

    function automatic logic cond_holds(input dpx_pkg::cond_t cond);
        logic n, z, c, v;
        {n, z, c, v} = nzcv_model;
        case (cond)
            dpx_pkg::COND_EQ: return z;
            dpx_pkg::COND_NE: return !z;
            dpx_pkg::COND_CS: return c;
            dpx_pkg::COND_CC: return !c;
            dpx_pkg::COND_MI: return n;
            dpx_pkg::COND_PL: return !n;
            dpx_pkg::COND_VS: return v;
            dpx_pkg::COND_VC: return !v;
            dpx_pkg::COND_HI: return c && !z;
            dpx_pkg::COND_LS: return !c || z;
            dpx_pkg::COND_GE: return n == v;
            dpx_pkg::COND_LT: return n != v;
            dpx_pkg::COND_GT: return !z && (n == v);
            dpx_pkg::COND_LE: return z || (n != v);
            dpx_pkg::COND_AL: return 1'b1;
            default: return 1'b0;
        endcase
    endfunction

    function automatic logic [31:0] barrel_shift(input logic [31:0] x,
                                                 input dpx_pkg::shift_t kind,
                                                 input logic [7:0] amt, input logic cin,
                                                 output logic cout);
        int sh;
        sh = int'(amt);
        cout = cin;
        if (sh == 0 || kind == dpx_pkg::SHIFT_ROR)
            return x;
        case (kind)
            dpx_pkg::SHIFT_LSL:
            begin
                if (sh < 32)
                begin
                    cout = x[32 - sh];
                    return x << sh;
                end
                cout = (sh == 32) ? x[0] : 1'b0;
                return '0;
            end
            dpx_pkg::SHIFT_LSR:
            begin
                if (sh < 32)
                begin
                    cout = x[sh - 1];
                    return x >> sh;
                end
                cout = (sh == 32) ? x[31] : 1'b0;
                return '0;
            end
            default:
            begin
                if (sh < 32)
                begin
                    cout = x[sh - 1];
                    return $signed(x) >>> sh;
                end
                cout = x[31];
                return {32{x[31]}};
            end
        endcase
    endfunction

    function automatic logic [31:0] add_carry(input logic [31:0] a, input logic [31:0] b,
                                              input logic cin, output logic cout,
                                              output logic ovf);
        logic [32:0] sum;
        sum = {1'b0, a} + {1'b0, b} + {32'd0, cin};
        cout = sum[32];
        ovf = ~(a[31] ^ b[31]) & (a[31] ^ sum[31]);
        return sum[31:0];
    endfunction

    // Advance the model by one instruction and queue the result it should produce.
    task automatic execute_model(input logic [31:0] w);
        step_result_t e;
        dpx_pkg::op_t opc;
        logic [31:0] a, b, res, rs_val, off;
        logic [7:0] amt;
        logic cin, sc, c, v, arith;
        e = '0;
        e.status = dpx_pkg::ST_EXECUTED;
        pc_model = pc_model + PC_STEP;
        cin = nzcv_model[1];
        if (!cond_holds(dpx_pkg::cond_t'(w[31:28])))
            e.status = dpx_pkg::ST_SKIPPED;
        else if (w[27:26] == dpx_pkg::CLASS_DP && w[7:4] == dpx_pkg::MUL_MARK)
        begin
            res = read_reg(w[3:0]) * read_reg(w[11:8]);
            if (w[21])
                res = res + read_reg(w[15:12]);
            e.wr = 1'b1;
            e.idx = w[19:16];
            e.val = res;
            if (w[20])
                nzcv_model = {res[31], res == 32'd0, nzcv_model[1:0]};
        end
        else if (w[27:26] == dpx_pkg::CLASS_DP)
        begin
            opc = dpx_pkg::op_t'(w[24:21]);
            a = read_reg(w[19:16]);
            if (w[25])
            begin
                b = {24'd0, w[7:0]};
                sc = cin;
            end
            else
            begin
                rs_val = read_reg(w[11:8]);
                amt = w[4] ? rs_val[7:0] : {3'b000, w[11:7]};
                b = barrel_shift(read_reg(w[3:0]), dpx_pkg::shift_t'(w[6:5]), amt, cin, sc);
            end
            arith = 1'b1;
            c = 1'b0;
            v = 1'b0;
            case (opc)
                dpx_pkg::OP_SUB, dpx_pkg::OP_CMP: res = add_carry(a, ~b, 1'b1, c, v);
                dpx_pkg::OP_RSB:                  res = add_carry(b, ~a, 1'b1, c, v);
                dpx_pkg::OP_ADD, dpx_pkg::OP_CMN: res = add_carry(a, b, 1'b0, c, v);
                dpx_pkg::OP_ADC:                  res = add_carry(a, b, cin, c, v);
                dpx_pkg::OP_SBC:                  res = add_carry(a, ~b, cin, c, v);
                dpx_pkg::OP_RSC:                  res = add_carry(b, ~a, cin, c, v);
                default:
                begin
                    arith = 1'b0;
                    case (opc)
                        dpx_pkg::OP_AND, dpx_pkg::OP_TST: res = a & b;
                        dpx_pkg::OP_EOR, dpx_pkg::OP_TEQ: res = a ^ b;
                        dpx_pkg::OP_ORR:                  res = a | b;
                        dpx_pkg::OP_MOV:                  res = b;
                        dpx_pkg::OP_BIC:                  res = a & ~b;
                        default:                          res = ~b;
                    endcase
                end
            endcase
            if (opc < dpx_pkg::OP_TST || opc > dpx_pkg::OP_CMN)
            begin
                e.wr = 1'b1;
                e.idx = w[15:12];
                e.val = res;
            end
            if (w[20])
            begin
                if (arith)
                    nzcv_model = {res[31], res == 32'd0, c, v};
                else
                    nzcv_model = {res[31], res == 32'd0, sc, nzcv_model[0]};
            end
        end
        else if (w[27:26] == dpx_pkg::CLASS_BRANCH && w[25])
        begin
            off = {{6{w[23]}}, w[23:0], 2'b00};
            if (w[24])
            begin
                e.wr = 1'b1;
                e.idx = dpx_pkg::REG_LINK;
                e.val = pc_model;
            end
            pc_model = pc_model + off;
        end
        else
            e.status = dpx_pkg::ST_UNSUPPORTED;

        if (e.wr)
        begin
            if (e.idx == dpx_pkg::REG_PC)
                pc_model = e.val;
            else
                gpr_model[e.idx] = e.val;
        end
        e.flags = nzcv_model;
        e.pc = pc_model;
        expected_q.push_back(e);
    endtask

    task automatic send_instr(input logic [31:0] w);
        int gap;
        instruction_valid <= 1'b1;
        instruction <= w;
        do
            @(posedge clk);
        while (instruction_stall);
        execute_model(w);
        gap = pick_gap();
        if (gap > 0)
        begin
            instruction_valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
    endtask

    // Hold off the sender until every queued result has come back.
    task automatic drain();
        instruction_valid <= 1'b0;
        while (expected_q.size() != 0)
            @(posedge clk);
        repeat (4) @(posedge clk);
    endtask

    task automatic report_mismatch(input string what, input logic [31:0] got,
                                   input logic [31:0] want);
        $display("%0t: mismatch on %s: got %h, want %h", $realtime, what, got, want);
        mismatches++;
    endtask

    always @(posedge clk)
    begin : check_result
        step_result_t want;
        if (rst_n && result_valid && !result_stall)
        begin
            if (expected_q.size() == 0)
                report_mismatch("unexpected beat", pc_out, '0);
            else
            begin
                want = expected_q.pop_front();
                if (status !== want.status)
                    report_mismatch("status", status, want.status);
                if (reg_written !== want.wr)
                    report_mismatch("reg_written", reg_written, want.wr);
                if (reg_index !== want.idx)
                    report_mismatch("reg_index", reg_index, want.idx);
                if (reg_value !== want.val)
                    report_mismatch("reg_value", reg_value, want.val);
                if (flags_out !== want.flags)
                    report_mismatch("flags_out", flags_out, want.flags);
                if (pc_out !== want.pc)
                    report_mismatch("pc_out", pc_out, want.pc);
            end
        end
    end

    always @(posedge clk)
    begin
        if (no_idle || !rst_n)
            result_stall <= 1'b0;
        else if (stall_left > 0)
        begin
            stall_left = stall_left - 1;
            result_stall <= 1'b1;
        end
        else if ($urandom_range(0, 99) < 30)
        begin
            stall_left = pick_gap();
            result_stall <= 1'b1;
        end
        else
            result_stall <= 1'b0;
    end

    function automatic logic [31:0] dp_imm(input dpx_pkg::cond_t cond, input dpx_pkg::op_t op,
                                           input logic s,
                                           input logic [3:0] rn, input logic [3:0] rd,
                                           input logic [7:0] imm);
        return {cond, dpx_pkg::CLASS_DP, 1'b1, op, s, rn, rd, 4'd0, imm};
    endfunction

    function automatic logic [31:0] dp_reg(input dpx_pkg::cond_t cond, input dpx_pkg::op_t op,
                                           input logic s,
                                           input logic [3:0] rn, input logic [3:0] rd,
                                           input logic [4:0] shamt, input dpx_pkg::shift_t kind,
                                           input logic [3:0] rm);
        return {cond, dpx_pkg::CLASS_DP, 1'b0, op, s, rn, rd, shamt, kind, 1'b0, rm};
    endfunction

    function automatic logic [31:0] dp_rsh(input dpx_pkg::op_t op, input logic [3:0] rd,
                                           input logic [3:0] rs, input dpx_pkg::shift_t kind,
                                           input logic [3:0] rm);
        return {dpx_pkg::COND_AL, dpx_pkg::CLASS_DP, 1'b0, op, 1'b1, 4'd0, rd, rs, 1'b0,
                kind, 1'b1, rm};
    endfunction

    function automatic logic [31:0] mul_word(input logic acc, input logic s,
                                             input logic [3:0] rd, input logic [3:0] ra,
                                             input logic [3:0] rs, input logic [3:0] rm);
        return {dpx_pkg::COND_AL, 6'd0, acc, s, rd, ra, rs, dpx_pkg::MUL_MARK, rm};
    endfunction

    function automatic logic [31:0] random_instr();
        logic [31:0] w;
        int pick;
        w = $urandom;
        pick = $urandom_range(0, 99);
        if ($urandom_range(0, 99) < 55)
            w[31:28] = dpx_pkg::COND_AL;
        if (pick < 68)
        begin
            w[27:26] = dpx_pkg::CLASS_DP;
            if (w[7:4] == dpx_pkg::MUL_MARK)
                w[7] = 1'b0;
            // refill registers with small values so register shifts stay in range
            if (pick < 15)
            begin
                w[25] = 1'b1;
                w[24:21] = dpx_pkg::OP_MOV;
            end
            if (w[15:12] == dpx_pkg::REG_PC && $urandom_range(0, 3) != 0)
                w[15:12] = 4'($urandom_range(0, 14));
        end
        else if (pick < 80)
        begin
            w[27:26] = dpx_pkg::CLASS_DP;
            w[7:4] = dpx_pkg::MUL_MARK;
            if (w[19:16] == dpx_pkg::REG_PC && $urandom_range(0, 3) != 0)
                w[19:16] = 4'($urandom_range(0, 14));
        end
        else if (pick < 90)
            w[27:25] = {dpx_pkg::CLASS_BRANCH, 1'b1};
        else
        begin
            case (pick % 3)
                0: w[27:26] = CLASS_XFER;
                1: w[27:26] = CLASS_COPROC;
                default:
                begin
                    w[27:26] = dpx_pkg::CLASS_BRANCH;
                    w[25] = 1'b0;
                end
            endcase
        end
        return w;
    endfunction

    task automatic test_alu_ops();
        logic [3:0] rn, rm;
        logic [4:0] shamt;
        send_instr(dp_imm(dpx_pkg::COND_AL, dpx_pkg::OP_MOV, 1'b1, 4'd0, 4'd1, 8'h81));
        send_instr(dp_imm(dpx_pkg::COND_AL, dpx_pkg::OP_MVN, 1'b1, 4'd0, 4'd2, 8'h00));
        send_instr(dp_reg(dpx_pkg::COND_AL, dpx_pkg::OP_MOV, 1'b0, 4'd0, 4'd4, 5'd24,
                          dpx_pkg::SHIFT_LSL, 4'd1));
        send_instr(dp_reg(dpx_pkg::COND_AL, dpx_pkg::OP_ADD, 1'b1, 4'd4, 4'd5, 5'd0,
                          dpx_pkg::SHIFT_LSL, 4'd4));
        for (int k = 0; k < 16; k++)
        begin
            rn = {1'b0, k[2:0]} + 4'd1;
            rm = 4'd5 - {2'b00, k[1:0]};
            shamt = {k[3:0], 1'b1};
            send_instr(dp_reg(dpx_pkg::COND_AL, dpx_pkg::op_t'(k[3:0]), 1'b1, rn, 4'd6, shamt,
                              dpx_pkg::shift_t'(k[1:0]), rm));
        end
    endtask

    task automatic test_shift_limits();
        send_instr(dp_imm(dpx_pkg::COND_AL, dpx_pkg::OP_MOV, 1'b0, 4'd0, 4'd7, 8'd32));
        // LSL by exactly 32: zero result, carry from bit 0
        send_instr(dp_rsh(dpx_pkg::OP_MOV, 4'd8, 4'd7, dpx_pkg::SHIFT_LSL, 4'd1));
        // ASR by 129 (low byte of r1): sign fill
        send_instr(dp_rsh(dpx_pkg::OP_MOV, 4'd9, 4'd1, dpx_pkg::SHIFT_ASR, 4'd4));
    endtask

    task automatic test_mul_branch_misc();
        send_instr(mul_word(1'b0, 1'b1, 4'd11, 4'd0, 4'd4, 4'd1));
        send_instr(mul_word(1'b1, 1'b0, 4'd12, 4'd2, 4'd1, 4'd1));
        send_instr({dpx_pkg::COND_AL, dpx_pkg::CLASS_BRANCH, 1'b1, 1'b1, 24'hFFFFFD});
        send_instr(dp_imm(dpx_pkg::COND_AL, dpx_pkg::OP_MOV, 1'b0, 4'd0, dpx_pkg::REG_PC,
                          8'h40));
        send_instr(dp_reg(dpx_pkg::COND_AL, dpx_pkg::OP_CMP, 1'b1, 4'd1, 4'd0, 5'd0,
                          dpx_pkg::SHIFT_LSL, 4'd1));
        send_instr(dp_imm(dpx_pkg::COND_LS, dpx_pkg::OP_MOV, 1'b0, 4'd0, 4'd3, 8'd1));
        send_instr(dp_imm(dpx_pkg::COND_LE, dpx_pkg::OP_MOV, 1'b0, 4'd0, 4'd3, 8'd2));
        send_instr(dp_imm(dpx_pkg::COND_NV, dpx_pkg::OP_MOV, 1'b0, 4'd0, 4'd3, 8'd3));
        send_instr({dpx_pkg::COND_AL, CLASS_XFER, 26'h2A5C3F1});
    endtask

    task automatic test_random_stream();
        for (int i = 0; i < 400; i++)
        begin
            if (i % 50 == 0)
                no_idle <= (i % 100 == 50);
            if (i == 200)
                drain();
            send_instr(random_instr());
        end
        drain();
    endtask

    initial
    begin
        for (int j = 0; j < dpx_pkg::NUM_GP; j++)
            gpr_model[j] = '0;
        pc_model = '0;
        nzcv_model = '0;
        repeat (10) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);
        test_alu_ops();
        test_shift_limits();
        test_mul_branch_misc();
        test_random_stream();
        repeat (10) @(posedge clk);
        if (mismatches == 0)
            $display("arm_data_processing_execute_tb OK");
        else
            $display("arm_data_processing_execute_tb NOT OK");
        $finish;
    end

endmodule

// File: filelist.f
rtl/dpx_pkg.sv
rtl/arm_data_processing_execute.sv
tb/arm_data_processing_execute_tb.sv
